/* hw/rtl/pcdl_pkg.sv */
// ----------------------------------------------------------------------------
// pcdl_pkg
// Shared types and constants of the PID controller with dead band and
// error low-pass filter: register indexes, sequencer states and the
// controller-to-datapath command.
// ----------------------------------------------------------------------------
package pcdl_pkg;

    localparam int FIELD_BITS    = 32;
    localparam int CFG_IDX_BITS  = 3;
    localparam int LIMIT_BITS    = 31;
    localparam int RATIO_BITS    = 17;
    localparam int BLEND_SHIFT   = 16;

    localparam logic [RATIO_BITS-1:0] RATIO_ONE = 17'd65536;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN_P    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN_I    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN_D    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INT_LIMIT = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OUT_LIMIT = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEAD_BAND = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BLEND     = 3'd6;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RAW,
        S_BL_OP,
        S_BL_MUL,
        S_ERR,
        S_D_OP,
        S_D_MUL,
        S_P_MUL,
        S_I_MUL,
        S_I_TERM,
        S_INTEG,
        S_DRIVE,
        S_CLEAR
    } t_state;

    typedef enum logic [3:0] {
        STEP_NONE,
        STEP_RAW,
        STEP_BL_OP,
        STEP_BL_MUL,
        STEP_ERR,
        STEP_D_OP,
        STEP_D_MUL,
        STEP_P_MUL,
        STEP_I_MUL,
        STEP_I_TERM,
        STEP_INTEG,
        STEP_DRIVE,
        STEP_CLEAR
    } t_step;

    typedef struct packed {
        logic  latch;
        t_step step;
    } t_dp_cmd;

endpackage

/* hw/rtl/pcdl_req_if.sv */
// ----------------------------------------------------------------------------
// pcdl_req_if
// Request channel: one item carries the request type and the two samples.
// ----------------------------------------------------------------------------
interface pcdl_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic signed [31:0] setpoint;
    logic signed [31:0] measured;

    modport source (output valid, output req_type, output setpoint, output measured,
                    input ready);
    modport sink   (input valid, input req_type, input setpoint, input measured,
                    output ready);
endinterface

/* hw/rtl/pcdl_rsp_if.sv */
// ----------------------------------------------------------------------------
// pcdl_rsp_if
// Response channel: one item carries the clamped drive value.
// ----------------------------------------------------------------------------
interface pcdl_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

/* hw/rtl/pid_controller_deadzone_lpf_core.sv */
// ----------------------------------------------------------------------------
// pid_controller_deadzone_lpf_core
// Positional PID step with dead band, error low-pass blend, clamped
// integral and clamped drive, in signed fixed point.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  i_req     in   valid/ready    req_type, setpoint, measured
//  o_rsp     out  valid/ready    drive
//  i_cfg_*   in   write enable   i_cfg_idx, i_cfg_data
//
//  A compute item passes through eleven sequencer steps around the one
//  shared multiplier (blend, then derivative, proportional and integral
//  products), then returns to idle; a clear item passes through the clear
//  step only. Each item gives one response item.
//  Reset is synchronous and active low; the gains and limits reset to zero,
//  the blend ratio to one, the error history and integral to zero.
//  The finished result waits in the output register; a stalled response
//  holds the sequencer in its final step, while the next request can be
//  taken as soon as that result is registered.
// ----------------------------------------------------------------------------
module pid_controller_deadzone_lpf_core
    import pcdl_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    pcdl_req_if.sink                i_req,
    pcdl_rsp_if.source              o_rsp,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [31:0]             i_cfg_data
);

    t_dp_cmd w_cmd;

    pcdl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_in_clear  (i_req.req_type),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (w_cmd)
    );

    pcdl_dp #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_setpoint (i_req.setpoint),
        .i_measured (i_req.measured),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_drive    (o_rsp.drive)
    );

endmodule

/* hw/rtl/pcdl_ctrl.sv */
// ----------------------------------------------------------------------------
// pcdl_ctrl
// Sequencer: walks one item through the datapath steps and owns the
// request ready and the response valid flag.
// ----------------------------------------------------------------------------
module pcdl_ctrl
    import pcdl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_clear,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd.latch = 1'b0;
        o_cmd.step  = STEP_NONE;
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = i_in_clear ? S_CLEAR : S_RAW;
                end
            end
            S_RAW: begin
                o_cmd.step = STEP_RAW;
                n_state    = S_BL_OP;
            end
            S_BL_OP: begin
                o_cmd.step = STEP_BL_OP;
                n_state    = S_BL_MUL;
            end
            S_BL_MUL: begin
                o_cmd.step = STEP_BL_MUL;
                n_state    = S_ERR;
            end
            S_ERR: begin
                o_cmd.step = STEP_ERR;
                n_state    = S_D_OP;
            end
            S_D_OP: begin
                o_cmd.step = STEP_D_OP;
                n_state    = S_D_MUL;
            end
            S_D_MUL: begin
                o_cmd.step = STEP_D_MUL;
                n_state    = S_P_MUL;
            end
            S_P_MUL: begin
                o_cmd.step = STEP_P_MUL;
                n_state    = S_I_MUL;
            end
            S_I_MUL: begin
                o_cmd.step = STEP_I_MUL;
                n_state    = S_I_TERM;
            end
            S_I_TERM: begin
                o_cmd.step = STEP_I_TERM;
                n_state    = S_INTEG;
            end
            S_INTEG: begin
                o_cmd.step = STEP_INTEG;
                n_state    = S_DRIVE;
            end
            S_DRIVE: begin
                // hold until the response slot is free
                if (w_slot_free) begin
                    o_cmd.step  = STEP_DRIVE;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_CLEAR: begin
                if (w_slot_free) begin
                    o_cmd.step  = STEP_CLEAR;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.step == STEP_DRIVE || o_cmd.step == STEP_CLEAR) |-> w_slot_free)
        else $error("pcdl_ctrl: result loaded over a pending item");

    a_compute_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !i_in_clear) |=> (r_state == S_RAW))
        else $error("pcdl_ctrl: compute item did not start the sequence");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DRIVE || $past(r_state) == S_CLEAR))
        else $error("pcdl_ctrl: result valid without a finishing step");

    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> !o_in_ready)
        else $error("pcdl_ctrl: second item accepted while one is in flight");

endmodule

/* hw/rtl/pcdl_dp.sv */
// ----------------------------------------------------------------------------
// pcdl_dp
// Datapath: configuration registers, controller state, one shared 33x33
// signed multiplier and the saturate/clamp logic, driven step by step.
// ----------------------------------------------------------------------------
module pcdl_dp
    import pcdl_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    input  logic signed [31:0]      i_setpoint,
    input  logic signed [31:0]      i_measured,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [31:0]             i_cfg_data,
    output logic signed [31:0]      o_drive
);

    // working width: internal values saturate to W bits
    localparam int W  = (DATA_WIDTH < FIELD_BITS) ? DATA_WIDTH : FIELD_BITS;
    localparam int OW = FIELD_BITS + 1;
    localparam int XW = 2 * OW;
    localparam logic signed [XW-1:0] SAT_HI = (XW'(1) << (W - 1)) - XW'(1);
    localparam logic signed [XW-1:0] SAT_LO = ~SAT_HI;

    function automatic logic signed [31:0] sat_w(input logic signed [XW-1:0] v);
        logic signed [31:0] res;
        if (v > SAT_HI) begin
            res = SAT_HI[31:0];
        end else if (v < SAT_LO) begin
            res = SAT_LO[31:0];
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic logic signed [XW-1:0] ext33(input logic signed [OW-1:0] v);
        return {{(XW-OW){v[OW-1]}}, v};
    endfunction

    function automatic logic signed [OW-1:0] ext32(input logic signed [31:0] v);
        return {v[31], v};
    endfunction

    function automatic logic signed [31:0] clamp_sym(input logic signed [31:0] v,
                                                     input logic [LIMIT_BITS-1:0] lim);
        logic signed [OW-1:0] pos;
        logic signed [OW-1:0] neg;
        logic signed [31:0]   res;
        pos = {2'b00, lim};
        neg = -pos;
        if (ext32(v) > pos) begin
            res = pos[31:0];
        end else if (ext32(v) < neg) begin
            res = neg[31:0];
        end else begin
            res = v;
        end
        return res;
    endfunction

    // configuration and controller state
    logic signed [31:0]     r_gain_p, r_gain_i, r_gain_d;
    logic [LIMIT_BITS-1:0]  r_int_limit, r_out_limit, r_dead_band;
    logic [RATIO_BITS-1:0]  r_blend;
    logic signed [31:0]     r_prev, r_integ;

    // working registers
    logic signed [31:0]     r_sp, r_ms, r_raw, r_err, r_term, r_acc, r_drive;
    logic signed [OW-1:0]   r_op_a, r_op_b;
    logic signed [XW-1:0]   r_prod;

    logic signed [OW-1:0]   w_diff;
    logic [OW-1:0]          w_mag;
    logic [RATIO_BITS-1:0]  w_ratio;
    logic signed [XW-1:0]   w_prod;
    logic signed [31:0]     w_delta;
    logic signed [31:0]     w_shifted;
    logic                   w_is_mul;

    assign w_diff    = ext32(r_sp) - ext32(r_ms);
    assign w_mag     = w_diff[OW-1] ? (~w_diff + OW'(1)) : w_diff;
    assign w_ratio   = (r_blend > RATIO_ONE) ? RATIO_ONE : r_blend;
    assign w_prod    = r_op_a * r_op_b;
    assign w_delta   = sat_w(ext33(ext32(r_err) - ext32(r_prev)));
    assign w_shifted = sat_w(r_prod >>> FRAC_BITS);
    assign w_is_mul  = (i_cmd.step == STEP_BL_MUL) || (i_cmd.step == STEP_D_MUL) ||
                       (i_cmd.step == STEP_P_MUL)  || (i_cmd.step == STEP_I_MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p    <= '0;
            r_gain_i    <= '0;
            r_gain_d    <= '0;
            r_int_limit <= '0;
            r_out_limit <= '0;
            r_dead_band <= '0;
            r_blend     <= RATIO_ONE;
            r_prev      <= '0;
            r_integ     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GAIN_P:    r_gain_p    <= i_cfg_data;
                    CFG_GAIN_I:    r_gain_i    <= i_cfg_data;
                    CFG_GAIN_D:    r_gain_d    <= i_cfg_data;
                    CFG_INT_LIMIT: r_int_limit <= i_cfg_data[LIMIT_BITS-1:0];
                    CFG_OUT_LIMIT: r_out_limit <= i_cfg_data[LIMIT_BITS-1:0];
                    CFG_DEAD_BAND: r_dead_band <= i_cfg_data[LIMIT_BITS-1:0];
                    CFG_BLEND:     r_blend     <= i_cfg_data[RATIO_BITS-1:0];
                    default: ;
                endcase
            end
            case (i_cmd.step)
                STEP_INTEG: begin
                    r_integ <= clamp_sym(sat_w(ext33(ext32(r_integ) + ext32(r_term))),
                                         r_int_limit);
                    r_prev  <= r_err;
                end
                STEP_CLEAR: begin
                    r_integ <= '0;
                    r_prev  <= '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_sp <= i_setpoint;
            r_ms <= i_measured;
        end
        if (w_is_mul) begin
            r_prod <= w_prod;
        end
        case (i_cmd.step)
            STEP_RAW: begin
                r_raw <= (w_mag < {2'b00, r_dead_band}) ? '0 : sat_w(ext33(w_diff));
            end
            STEP_BL_OP: begin
                // blend = prev + (raw - prev) * ratio / 2^16
                r_op_a <= ext32(r_raw) - ext32(r_prev);
                r_op_b <= {{(OW-RATIO_BITS){1'b0}}, w_ratio};
            end
            STEP_ERR: begin
                r_err <= sat_w(ext33(ext32(r_prev)) + (r_prod >>> BLEND_SHIFT));
            end
            STEP_D_OP: begin
                r_op_a <= ext32(w_delta);
                r_op_b <= ext32(r_gain_d);
            end
            STEP_D_MUL: begin
                r_op_a <= ext32(r_err);
                r_op_b <= ext32(r_gain_p);
            end
            STEP_P_MUL: begin
                r_term <= w_shifted;
                r_op_b <= ext32(r_gain_i);
            end
            STEP_I_MUL: begin
                r_acc  <= r_term;
                r_term <= w_shifted;
            end
            STEP_I_TERM: begin
                r_acc  <= sat_w(ext33(ext32(r_acc) + ext32(r_term)));
                r_term <= w_shifted;
            end
            STEP_DRIVE: begin
                r_drive <= clamp_sym(sat_w(ext33(ext32(r_acc) + ext32(r_integ))),
                                     r_out_limit);
            end
            STEP_CLEAR: begin
                r_drive <= '0;
            end
            default: ;
        endcase
    end

    assign o_drive = r_drive;

endmodule
